// File: sv/hct_pkg.sv
`default_nettype none
package hct_pkg;

	localparam int ANGLE_W  = 8;
	localparam int GAIN_W   = 12;
	localparam int OFFSET_W = 10;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int REG_W    = ADDR_W - 2;
	localparam int Q_SHIFT  = 10;

	localparam logic [REG_W-1:0] REG_STEP    = 3'd0;
	localparam logic [REG_W-1:0] REG_GAIN    = 3'd1;
	localparam logic [REG_W-1:0] REG_OFFSET  = 3'd2;
	localparam logic [REG_W-1:0] REG_START_X = 3'd3;
	localparam logic [REG_W-1:0] REG_START_Y = 3'd4;

	localparam logic [1:0] PH_UP_REF   = 2'd0;
	localparam logic [1:0] PH_UP_CLIMB = 2'd1;
	localparam logic [1:0] PH_DN_REF   = 2'd2;
	localparam logic [1:0] PH_DN_CLIMB = 2'd3;

	localparam logic AXIS_Y = 1'b0;
	localparam logic AXIS_X = 1'b1;

	localparam logic [ANGLE_W-1:0]  RST_STEP   = 8'd10;
	localparam logic [GAIN_W-1:0]   RST_GAIN   = 12'd535;
	localparam logic [OFFSET_W-1:0] RST_OFFSET = 10'd29;

endpackage
`default_nettype wire

// File: sv/two_axis_hill_climb_tracker.sv
`default_nettype none
// Two-axis hill-climbing sun tracker. Each sample request carries one light level measured
// at the angles of the previous result, and gives exactly one result: both angles, both
// servo pulse counts, the axis and phase the next sample belongs to, and on the sample that
// ends an axis search the best level found. The search climbs axis y up then down from its
// origin, sets the better side (up on a tie), then does the same on axis x, and repeats.
// A sample with restart set loads the start angles and begins again on axis y.
// One sample is taken every cycle into the input register unless a result waits, which holds
// the whole pipeline; search state update, then pulse multiply into the result register.
// pulse = (angle * pulse_gain_q10) >> 10 + pulse_offset, saturated at all ones. The user must
// write the configuration registers over the APB port at byte addresses 0, 4, 8, 12, 16 (step,
// gain, offset, start x, start y) only while no sample is in flight; the block does not check.
module two_axis_hill_climb_tracker #(
	parameter int MAX_ANGLE  = 180,
	parameter int LEVEL_BITS = 12,
	parameter int PULSE_BITS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hct_pkg::ADDR_W-1:0]   paddr,
	input  logic [hct_pkg::DATA_W-1:0]   pwdata,
	output logic [hct_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         sample_valid,
	output logic                         sample_ready,
	input  logic [LEVEL_BITS-1:0]        light_level,
	input  logic                         restart,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [hct_pkg::ANGLE_W-1:0]  angle_x,
	output logic [hct_pkg::ANGLE_W-1:0]  angle_y,
	output logic [PULSE_BITS-1:0]        pulse_x,
	output logic [PULSE_BITS-1:0]        pulse_y,
	output logic                         active_axis,
	output logic [1:0]                   search_phase,
	output logic                         axis_done,
	output logic [LEVEL_BITS-1:0]        best_level
);
	import hct_pkg::*;

	localparam logic [ANGLE_W-1:0] MAX_A = ANGLE_W'(MAX_ANGLE);
	localparam int PROD_W = ANGLE_W + GAIN_W;
	localparam int SUM_W  = (PULSE_BITS > OFFSET_W + 1) ? PULSE_BITS : OFFSET_W + 1;
	localparam logic [SUM_W-1:0] PULSE_MAX = SUM_W'((64'd1 << PULSE_BITS) - 64'd1);

	logic [ANGLE_W-1:0]  step_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [ANGLE_W-1:0]  start_x_q;
	logic [ANGLE_W-1:0]  start_y_q;

	logic                cfg_wr;
	logic [REG_W-1:0]    cfg_idx;

	logic                  adv;
	logic                  valid_s1, valid_s2, valid_s3;
	logic [LEVEL_BITS-1:0] level_s1;
	logic                  restart_s1;

	logic [1:0]            phase_q, phase_n;
	logic                  axis_q, axis_n;
	logic [ANGLE_W-1:0]    cur_x_q, cur_x_n, cur_y_q, cur_y_n;
	logic [ANGLE_W-1:0]    origin_q, origin_n, trial_q, trial_n, good_q, good_n;
	logic [LEVEL_BITS-1:0] ref_q, ref_n, up_level_q, up_level_n;
	logic [ANGLE_W-1:0]    up_angle_q, up_angle_n;
	logic                  done_c, done_s2;
	logic [LEVEL_BITS-1:0] best_c, best_s2;

	logic [ANGLE_W-1:0]    angle_x_s3, angle_y_s3;
	logic [PULSE_BITS-1:0] pulse_x_s3, pulse_y_s3;
	logic                  axis_s3, done_s3;
	logic [1:0]            phase_s3;
	logic [LEVEL_BITS-1:0] best_s3;

	function automatic logic [ANGLE_W-1:0] sat_angle(input logic [ANGLE_W-1:0] a);
		return (a > MAX_A) ? MAX_A : a;
	endfunction

	function automatic logic [ANGLE_W-1:0] step_up(input logic [ANGLE_W-1:0] a,
			input logic [ANGLE_W-1:0] s);
		logic [ANGLE_W:0] t;
		t = {1'b0, a} + {1'b0, s};
		return (t >= {1'b0, MAX_A}) ? MAX_A : t[ANGLE_W-1:0];
	endfunction

	function automatic logic [ANGLE_W-1:0] step_down(input logic [ANGLE_W-1:0] a,
			input logic [ANGLE_W-1:0] s);
		return (a >= s) ? a - s : '0;
	endfunction

	function automatic logic [PULSE_BITS-1:0] to_pulse(input logic [ANGLE_W-1:0] a,
			input logic [GAIN_W-1:0] g, input logic [OFFSET_W-1:0] o);
		logic [PROD_W-1:0] prod;
		logic [SUM_W-1:0]  sum;
		prod = PROD_W'(a) * PROD_W'(g);
		sum  = SUM_W'(prod[PROD_W-1:Q_SHIFT]) + SUM_W'(o);
		return (sum > PULSE_MAX) ? PULSE_MAX[PULSE_BITS-1:0] : sum[PULSE_BITS-1:0];
	endfunction

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= RST_STEP;
			gain_q    <= RST_GAIN;
			offset_q  <= RST_OFFSET;
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_STEP:    step_q    <= pwdata[ANGLE_W-1:0];
				REG_GAIN:    gain_q    <= pwdata[GAIN_W-1:0];
				REG_OFFSET:  offset_q  <= pwdata[OFFSET_W-1:0];
				REG_START_X: start_x_q <= pwdata[ANGLE_W-1:0];
				REG_START_Y: start_y_q <= pwdata[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_STEP:    prdata = DATA_W'(step_q);
			REG_GAIN:    prdata = DATA_W'(gain_q);
			REG_OFFSET:  prdata = DATA_W'(offset_q);
			REG_START_X: prdata = DATA_W'(start_x_q);
			REG_START_Y: prdata = DATA_W'(start_y_q);
			default:     prdata = '0;
		endcase
	end

	// whole pipeline moves together
	assign adv          = !valid_s3 || result_ready;
	assign sample_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= sample_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_s1   <= light_level;
			restart_s1 <= restart;
		end
	end

	// search step
	always_comb begin
		phase_n    = phase_q;
		axis_n     = axis_q;
		cur_x_n    = cur_x_q;
		cur_y_n    = cur_y_q;
		origin_n   = origin_q;
		trial_n    = trial_q;
		good_n     = good_q;
		ref_n      = ref_q;
		up_level_n = up_level_q;
		up_angle_n = up_angle_q;
		done_c     = 1'b0;
		best_c     = '0;
		if (restart_s1) begin
			cur_x_n  = sat_angle(start_x_q);
			cur_y_n  = sat_angle(start_y_q);
			axis_n   = AXIS_Y;
			phase_n  = PH_UP_REF;
			origin_n = sat_angle(start_y_q);
		end else begin
			unique case (phase_q)
				PH_UP_REF: begin
					ref_n   = level_s1;
					good_n  = origin_q;
					trial_n = step_up(origin_q, step_q);
					phase_n = PH_UP_CLIMB;
				end
				PH_UP_CLIMB: begin
					if (level_s1 > ref_q) begin
						ref_n   = level_s1;
						good_n  = trial_q;
						trial_n = step_up(trial_q, step_q);
					end else begin
						up_level_n = ref_q;
						up_angle_n = good_q;
						phase_n    = PH_DN_REF;
					end
				end
				PH_DN_REF: begin
					ref_n   = level_s1;
					good_n  = origin_q;
					trial_n = step_down(origin_q, step_q);
					phase_n = PH_DN_CLIMB;
				end
				PH_DN_CLIMB: begin
					if (level_s1 > ref_q) begin
						ref_n   = level_s1;
						good_n  = trial_q;
						trial_n = step_down(trial_q, step_q);
					end else begin
						done_c   = 1'b1;
						best_c   = (up_level_q >= ref_q) ? up_level_q : ref_q;
						axis_n   = ~axis_q;
						origin_n = (axis_q == AXIS_X) ? cur_y_q : cur_x_q;
						phase_n  = PH_UP_REF;
					end
				end
				default: ;
			endcase
		end
	end

	// commanded angle of the axis under search
	logic [ANGLE_W-1:0] axis_angle_c;
	logic               axis_set_c;

	always_comb begin
		axis_set_c   = 1'b0;
		axis_angle_c = trial_n;
		if (!restart_s1) begin
			unique case (phase_q)
				PH_UP_REF, PH_DN_REF: begin
					axis_set_c   = 1'b1;
					axis_angle_c = trial_n;
				end
				PH_UP_CLIMB: begin
					axis_set_c   = 1'b1;
					axis_angle_c = (level_s1 > ref_q) ? trial_n : origin_q;
				end
				PH_DN_CLIMB: begin
					axis_set_c = 1'b1;
					if (level_s1 > ref_q) begin
						axis_angle_c = trial_n;
					end else begin
						axis_angle_c = (up_level_q >= ref_q) ? up_angle_q : good_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_UP_REF;
			axis_q     <= AXIS_Y;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			origin_q   <= '0;
			trial_q    <= '0;
			good_q     <= '0;
			ref_q      <= '0;
			up_level_q <= '0;
			up_angle_q <= '0;
		end else if (adv && valid_s1) begin
			phase_q    <= phase_n;
			axis_q     <= axis_n;
			origin_q   <= origin_n;
			trial_q    <= trial_n;
			good_q     <= good_n;
			ref_q      <= ref_n;
			up_level_q <= up_level_n;
			up_angle_q <= up_angle_n;
			cur_x_q    <= (axis_set_c && axis_q == AXIS_X) ? axis_angle_c : cur_x_n;
			cur_y_q    <= (axis_set_c && axis_q == AXIS_Y) ? axis_angle_c : cur_y_n;
		end
	end

	// the search state doubles as the second stage's angles, axis and phase
	always_ff @(posedge clk) begin
		if (adv) begin
			done_s2 <= done_c;
			best_s2 <= best_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_x_s3 <= cur_x_q;
			angle_y_s3 <= cur_y_q;
			pulse_x_s3 <= to_pulse(cur_x_q, gain_q, offset_q);
			pulse_y_s3 <= to_pulse(cur_y_q, gain_q, offset_q);
			axis_s3    <= axis_q;
			phase_s3   <= phase_q;
			done_s3    <= done_s2;
			best_s3    <= best_s2;
		end
	end

	assign result_valid = valid_s3;
	assign angle_x      = angle_x_s3;
	assign angle_y      = angle_y_s3;
	assign pulse_x      = pulse_x_s3;
	assign pulse_y      = pulse_y_s3;
	assign active_axis  = axis_s3;
	assign search_phase = phase_s3;
	assign axis_done    = done_s3;
	assign best_level   = best_s3;

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && axis_done |-> search_phase == PH_UP_REF)
		else $error("axis finished but next phase is not the up reference");

	a_best_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !axis_done |-> best_level == '0)
		else $error("best level set without a finished axis");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> cur_x_q <= MAX_A && cur_y_q <= MAX_A)
		else $error("commanded angle beyond limit");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && restart_s1 |=> phase_q == PH_UP_REF && axis_q == AXIS_Y
			&& !done_s2)
		else $error("restart did not begin the y search");

endmodule
`default_nettype wire
